FILE: design/svt_pkg.sv
`default_nettype none

package svt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DATA_W = 32;
  localparam int OP_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_FIRST = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic en;
    logic ins;
    logic use_lt;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic lt;
    logic hit;
    logic tail;
  } cell_flags_t;

endpackage

`default_nettype wire

FILE: design/svt_cell.sv
`default_nettype none

module svt_cell (
  input  wire logic                              clk,
  input  wire svt_pkg::cell_ctl_t                ctl,
  input  wire logic                              valid,
  input  wire logic                              left_lt,
  input  wire logic signed [svt_pkg::DATA_W-1:0] left_entry,
  input  wire logic signed [svt_pkg::DATA_W-1:0] right_entry,
  input  wire logic                              right_valid,
  output logic signed [svt_pkg::DATA_W-1:0]      entry,
  output svt_pkg::cell_flags_t                   flags
);
  import svt_pkg::*;

  logic signed [DATA_W-1:0] entry_next;
  logic lt;

  assign lt = valid && (entry < ctl.value);

  always_comb begin
    flags.lt = lt;
    flags.hit = !lt && left_lt && valid && (entry == ctl.value);
    flags.tail = valid && !right_valid;
  end

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (!lt) begin
        entry_next = left_lt ? ctl.value : left_entry;
      end
    end else if (!(ctl.use_lt && lt)) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/sorted_value_table.sv
// sorted_value_table: holds up to CAPACITY signed 32-bit values in ascending
// order in a row of cells, each cell one entry.
// input channel: in_valid/in_ready with op and value; output channel:
// out_valid/out_ready with status, removed_value and count, one result item
// per input item, in order.
// every cell compares its entry with the item's value at once; an insert
// shifts the upper part of the row one cell right, a remove one cell left
// and remove-last only drops the count; each ends in the accept cycle.
// the result is registered and shows in the cycle after acceptance.
// throughput: one item per cycle while the receiver keeps up; a new item is
// taken in the same cycle the previous result leaves, set by the single
// output register. when the receiver stalls, the result holds and in_ready
// drops until it is taken, so no item is lost.
// reset empties the table at once; cell contents above the count are not
// cleared and are never seen. no clearing pass is needed.
`default_nettype none

module sorted_value_table (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [svt_pkg::OP_W-1:0]            op,
  input  wire logic signed [svt_pkg::DATA_W-1:0]   value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [svt_pkg::STATUS_W-1:0]             status,
  output logic signed [svt_pkg::DATA_W-1:0]        removed_value,
  output logic [svt_pkg::COUNT_W-1:0]              count
);
  import svt_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic accept;
  cell_ctl_t ctl;
  logic signed [DATA_W-1:0] entry [CAPACITY];
  cell_flags_t flags [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] tail_vec;
  logic found;
  logic full;
  logic empty;
  logic signed [DATA_W-1:0] hit_value;
  logic signed [DATA_W-1:0] tail_value;
  logic [STATUS_W-1:0] status_next;
  logic signed [DATA_W-1:0] removed_next;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic left_lt;
      logic signed [DATA_W-1:0] left_entry;
      logic signed [DATA_W-1:0] right_entry;
      logic right_valid;

      assign valid_vec[g] = cnt > CNT_W'(g);
      assign hit_vec[g] = flags[g].hit;
      assign tail_vec[g] = flags[g].tail;

      if (g == 0) begin : g_first
        assign left_lt = 1'b1;
        assign left_entry = value;
      end else begin : g_mid
        assign left_lt = flags[g-1].lt;
        assign left_entry = entry[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign right_entry = entry[g];
        assign right_valid = 1'b0;
      end else begin : g_inner
        assign right_entry = entry[g+1];
        assign right_valid = valid_vec[g+1];
      end

      svt_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .valid       (valid_vec[g]),
        .left_lt     (left_lt),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .right_valid (right_valid),
        .entry       (entry[g]),
        .flags       (flags[g])
      );
    end
  endgenerate

  assign found = |hit_vec;
  assign full = cnt == CNT_W'(CAPACITY);
  assign empty = cnt == '0;

  always_comb begin
    hit_value = '0;
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (hit_vec[i] ? entry[i] : '0);
      tail_value = tail_value | (tail_vec[i] ? entry[i] : '0);
    end
  end

  always_comb begin
    ctl.en = 1'b0;
    ctl.ins = 1'b0;
    ctl.use_lt = 1'b0;
    ctl.value = value;
    cnt_next = cnt;
    status_next = ST_OK;
    removed_next = '0;
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.en = accept;
          ctl.ins = 1'b1;
          ctl.use_lt = 1'b1;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      OP_SEARCH: begin
        status_next = found ? ST_OK : ST_NOT_FOUND;
      end
      OP_REMOVE: begin
        if (found) begin
          ctl.en = accept;
          ctl.use_lt = 1'b1;
          removed_next = hit_value;
          cnt_next = cnt - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_REMOVE_FIRST: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.en = accept;
          removed_next = entry[0];
          cnt_next = cnt - CNT_W'(1);
        end
      end
      OP_REMOVE_LAST: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          removed_next = tail_value;
          cnt_next = cnt - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      removed_value <= removed_next;
      count <= COUNT_W'(cnt_next);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_hit_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell at the match boundary");

  a_tail_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tail_vec) && (empty || $onehot(tail_vec)))
    else $error("tail cell not unique");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_INSERT && !full |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("insert did not grow the table");
`endif

endmodule

`default_nettype wire
